/* design/drma_pkg.sv */
package drma_pkg;

   // fixed field widths
   localparam int CH_IN_W    = 3;
   localparam int SMP_W      = 12;
   localparam int FIX_W      = 20;
   localparam int LIM_W      = 24;
   localparam int RES_W      = 24;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 24;
   localparam int CHAN_CMP_W = 7;

   // converter full scale and the 1 mV floor as 3300 * sum >= 4095 * window
   localparam int ADC_FULL     = 4095;
   localparam int LOW_MV_SCALE = 3300;
   localparam int LOW_MV_W     = 12;

   localparam logic [FIX_W-1:0] FIX_RESET = FIX_W'(10000);
   localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(2000000);

   localparam int DEF_CHANNELS = 8;
   localparam int DEF_WINDOW   = 16;
   localparam int QUEUE_DEPTH  = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIXED_OHMS = 1'b0,
      CSR_OPEN_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      REQ_PRIME   = 1'b0,
      REQ_MEASURE = 1'b1
   } req_kind_type;

   typedef struct packed {
      req_kind_type       req_kind;
      logic [CH_IN_W-1:0] channel;
      logic [SMP_W-1:0]   sample;
      logic               end_of_scan;
   } cmd_item_type;

   typedef struct packed {
      logic [CH_IN_W-1:0] channel_out;
      logic [RES_W-1:0]   resistance_ohms;
      logic               reading_valid;
      logic               scan_done;
      logic               scan_valid;
   } rsp_item_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_RD_CH,
      S_RD_SMP,
      S_UPDATE,
      S_CHECK,
      S_MUL_LO,
      S_MUL_HI,
      S_ADD,
      S_DIV_INIT,
      S_DIV,
      S_DONE
   } back_state_type;

endpackage

/* design/divider_resistance_moving_average_top.sv */
// Per-channel moving average of converter samples with a voltage divider
// resistance estimate on measure transactions.
// Request side is a queue write port: a transaction is taken when push is
// high and full is low. Prime transactions only update the channel window;
// measure transactions yield one response. Channels at or above CHANNELS are
// taken and dropped without effect.
// Response side is a queue read port: the oldest response sits on the rsp_
// ports while empty is low and leaves when pop is high.
// Configuration writes on the csr_ channel are always ready and are meant to
// be issued only while no request is in flight.
// The back end takes one transaction at a time: a prime reads and rewrites the
// channel state and window slot; a measure then adds a 1 mV check, multiply,
// add and the 24-step divider; below 1 mV it stops at the check, on overflow before the divide.
// Two-entry queues sit on both sides of the back end, so new requests are
// taken while a response waits; when pop stays low the response queue fills
// and the back end then holds its finished result until space frees up.
// After reset, full stays high while the window memory is swept to zero; sums
// and pointers start at zero, scan flag set.
module divider_resistance_moving_average_top #(
   parameter int CHANNELS = drma_pkg::DEF_CHANNELS,
   parameter int WINDOW   = drma_pkg::DEF_WINDOW
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic                              req_type,
   input  logic [drma_pkg::CH_IN_W-1:0]      req_channel,
   input  logic [drma_pkg::SMP_W-1:0]        req_sample,
   input  logic                              req_end_of_scan,
   output logic                              empty,
   input  logic                              pop,
   output logic [drma_pkg::CH_IN_W-1:0]      rsp_channel_out,
   output logic [drma_pkg::RES_W-1:0]        rsp_resistance_ohms,
   output logic                              rsp_reading_valid,
   output logic                              rsp_scan_done,
   output logic                              rsp_scan_valid,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [drma_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [drma_pkg::CSR_DATA_W-1:0]   csr_data
);
   import drma_pkg::*;

   logic [FIX_W-1:0] fixed_ohms_ff, fixed_ohms_in;
   logic [LIM_W-1:0] open_limit_ff, open_limit_in;

   cmd_item_type cmd_wr, cmd_rd;
   rsp_item_type rsp_wr, rsp_rd;
   logic         cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic         rsp_push, rsp_full;
   logic         clearing;

   assign csr_ready = 1'b1;

   always_comb begin
      fixed_ohms_in = fixed_ohms_ff;
      open_limit_in = open_limit_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_FIXED_OHMS: fixed_ohms_in = csr_data[FIX_W-1:0];
            CSR_OPEN_LIMIT: open_limit_in = csr_data[LIM_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fixed_ohms_ff <= FIX_RESET;
         open_limit_ff <= LIM_RESET;
      end else begin
         fixed_ohms_ff <= fixed_ohms_in;
         open_limit_ff <= open_limit_in;
      end
   end

   drma_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .push            (push),
      .full            (full),
      .req_type        (req_type),
      .req_channel     (req_channel),
      .req_sample      (req_sample),
      .req_end_of_scan (req_end_of_scan),
      .clearing        (clearing),
      .cmd_full        (cmd_full),
      .cmd_push        (cmd_push),
      .cmd_item        (cmd_wr)
   );

   drma_fifo #(
      .WIDTH ($bits(cmd_item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_wr),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_rd),
      .empty   (cmd_empty)
   );

   drma_back #(
      .CHANNELS (CHANNELS),
      .WINDOW   (WINDOW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .fixed_ohms (fixed_ohms_ff),
      .open_limit (open_limit_ff),
      .cmd_empty  (cmd_empty),
      .cmd_pop    (cmd_pop),
      .cmd_item   (cmd_rd),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_item   (rsp_wr),
      .clearing   (clearing)
   );

   drma_fifo #(
      .WIDTH ($bits(rsp_item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_wr),
      .full    (rsp_full),
      .pop     (pop),
      .rd_data (rsp_rd),
      .empty   (empty)
   );

   assign rsp_channel_out     = rsp_rd.channel_out;
   assign rsp_resistance_ohms = rsp_rd.resistance_ohms;
   assign rsp_reading_valid   = rsp_rd.reading_valid;
   assign rsp_scan_done       = rsp_rd.scan_done;
   assign rsp_scan_valid      = rsp_rd.scan_valid;

endmodule

/* design/drma_fifo.sv */
module drma_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* design/drma_front.sv */
module drma_front #(
   parameter int CHANNELS = 8
) (
   input  logic                           push,
   output logic                           full,
   input  logic                           req_type,
   input  logic [drma_pkg::CH_IN_W-1:0]   req_channel,
   input  logic [drma_pkg::SMP_W-1:0]     req_sample,
   input  logic                           req_end_of_scan,
   input  logic                           clearing,
   input  logic                           cmd_full,
   output logic                           cmd_push,
   output drma_pkg::cmd_item_type         cmd_item
);
   import drma_pkg::*;

   logic in_range;

   // hold off while the window memory is being swept after reset
   assign full = cmd_full || clearing;

   // items for channels that do not exist are taken and dropped
   assign in_range = (CHAN_CMP_W'(req_channel) < CHAN_CMP_W'(CHANNELS));
   assign cmd_push = push && !full && in_range;

   always_comb begin
      cmd_item.req_kind    = req_kind_type'(req_type);
      cmd_item.channel     = req_channel;
      cmd_item.sample      = req_sample;
      cmd_item.end_of_scan = req_end_of_scan;
   end

endmodule

/* design/drma_back.sv */
module drma_back #(
   parameter int CHANNELS = 8,
   parameter int WINDOW   = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [drma_pkg::FIX_W-1:0]   fixed_ohms,
   input  logic [drma_pkg::LIM_W-1:0]   open_limit,
   input  logic                         cmd_empty,
   output logic                         cmd_pop,
   input  drma_pkg::cmd_item_type       cmd_item,
   input  logic                         rsp_full,
   output logic                         rsp_push,
   output drma_pkg::rsp_item_type       rsp_item,
   output logic                         clearing
);
   import drma_pkg::*;

   localparam int DEPTH   = CHANNELS * WINDOW;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PTR_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int FULL    = ADC_FULL * WINDOW;
   localparam int SUM_W   = $clog2(FULL + 1);
   localparam int MUL_B_W = (SUM_W + 1) / 2;
   localparam int DIFF_W  = 2 * MUL_B_W;
   localparam int PROD_W  = FIX_W + MUL_B_W;
   localparam int NUM_W   = FIX_W + DIFF_W;
   localparam int HI_W    = NUM_W - RES_W;
   localparam int CMP_W   = (HI_W > SUM_W) ? HI_W : SUM_W;
   localparam int LOW_W   = SUM_W + LOW_MV_W;
   localparam int CNT_W   = $clog2(RES_W);
   localparam int CST_W   = SUM_W + PTR_W;

   // window samples and per-channel {sum, pointer}
   logic [SMP_W-1:0] smp_mem [DEPTH];
   logic [CST_W-1:0] chan_mem [CHANNELS];

   back_state_type    state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   cmd_item_type      cmd_ff, cmd_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              low_ff, low_in;
   logic              ovf_ff, ovf_in;
   logic [DIFF_W-1:0] diff_ff, diff_in;
   logic [PROD_W-1:0] prod_lo_ff, prod_lo_in;
   logic [PROD_W-1:0] prod_hi_ff, prod_hi_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [RES_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              scan_ff, scan_in;
   logic [CST_W-1:0]  chan_rd_ff;
   logic [SMP_W-1:0]  smp_rd_ff;

   logic [CH_W-1:0]   ch_idx;
   logic [PTR_W-1:0]  rd_ptr, next_ptr;
   logic [SUM_W-1:0]  rd_sum, new_sum;
   logic [ADDR_W-1:0] smp_addr;
   logic              smp_we;
   logic [ADDR_W-1:0] smp_waddr;
   logic [SMP_W-1:0]  smp_wdata;
   logic              chan_we;
   logic [CH_W-1:0]   chan_waddr;
   logic [CST_W-1:0]  chan_wdata;
   logic [SUM_W:0]    rem_shift;
   logic              rem_ge;
   logic              valid;
   logic              scan_all;

   assign ch_idx   = CH_W'(cmd_ff.channel);
   assign rd_ptr   = chan_rd_ff[PTR_W-1:0];
   assign rd_sum   = chan_rd_ff[PTR_W +: SUM_W];
   assign smp_addr = ADDR_W'(ch_idx) * ADDR_W'(WINDOW) + ADDR_W'(rd_ptr);
   assign new_sum  = rd_sum - SUM_W'(smp_rd_ff) + SUM_W'(cmd_ff.sample);
   assign next_ptr = (rd_ptr == PTR_W'(WINDOW - 1)) ? '0 : rd_ptr + 1'b1;
   assign clearing = (state_ff == S_CLEAR);

   // restoring divide step, dividend bits shift out of the top of quo
   assign rem_shift = {rem_ff, quo_ff[RES_W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, sum_ff});

   // exact limit check: a quotient equal to the limit passes only with no remainder
   assign valid    = !low_ff && !ovf_ff &&
                     ((quo_ff < open_limit) || ((quo_ff == open_limit) && (rem_ff == '0)));
   assign scan_all = scan_ff && valid;

   always_comb begin
      rsp_item.channel_out     = cmd_ff.channel;
      rsp_item.resistance_ohms = valid ? quo_ff : '0;
      rsp_item.reading_valid   = valid;
      rsp_item.scan_done       = cmd_ff.end_of_scan;
      rsp_item.scan_valid      = cmd_ff.end_of_scan && scan_all;
   end

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      cmd_in     = cmd_ff;
      sum_in     = sum_ff;
      low_in     = low_ff;
      ovf_in     = ovf_ff;
      diff_in    = diff_ff;
      prod_lo_in = prod_lo_ff;
      prod_hi_in = prod_hi_ff;
      num_in     = num_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      scan_in    = scan_ff;
      smp_we     = 1'b0;
      smp_waddr  = smp_addr;
      smp_wdata  = cmd_ff.sample;
      chan_we    = 1'b0;
      chan_waddr = ch_idx;
      chan_wdata = {new_sum, next_ptr};
      cmd_pop    = 1'b0;
      rsp_push   = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            smp_we    = 1'b1;
            smp_waddr = clr_ff;
            smp_wdata = '0;
            if (int'(clr_ff) < CHANNELS) begin
               chan_we    = 1'b1;
               chan_waddr = CH_W'(clr_ff);
               chan_wdata = '0;
            end
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_item;
               state_in = S_RD_CH;
            end
         end
         S_RD_CH: begin
            state_in = S_RD_SMP;
         end
         S_RD_SMP: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            smp_we  = 1'b1;
            chan_we = 1'b1;
            sum_in  = new_sum;
            state_in = (cmd_ff.req_kind == REQ_MEASURE) ? S_CHECK : S_IDLE;
         end
         S_CHECK: begin
            low_in  = (LOW_W'(sum_ff) * LOW_W'(LOW_MV_SCALE) < LOW_W'(FULL))
                      || (sum_ff == '0);
            diff_in = DIFF_W'(SUM_W'(FULL) - sum_ff);
            state_in = low_in ? S_DONE : S_MUL_LO;
         end
         S_MUL_LO: begin
            prod_lo_in = PROD_W'(fixed_ohms) * PROD_W'(diff_ff[MUL_B_W-1:0]);
            state_in   = S_MUL_HI;
         end
         S_MUL_HI: begin
            prod_hi_in = PROD_W'(fixed_ohms) * PROD_W'(diff_ff[DIFF_W-1:MUL_B_W]);
            state_in   = S_ADD;
         end
         S_ADD: begin
            num_in   = NUM_W'(prod_lo_ff) + (NUM_W'(prod_hi_ff) << MUL_B_W);
            state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            // quotient needs more than the field width: past any limit
            ovf_in   = (CMP_W'(num_ff[NUM_W-1:RES_W]) >= CMP_W'(sum_ff));
            rem_in   = SUM_W'(num_ff[NUM_W-1:RES_W]);
            quo_in   = num_ff[RES_W-1:0];
            cnt_in   = '0;
            state_in = ovf_in ? S_DONE : S_DIV;
         end
         S_DIV: begin
            rem_in = rem_ge ? SUM_W'(rem_shift - {1'b0, sum_ff})
                            : rem_shift[SUM_W-1:0];
            quo_in = {quo_ff[RES_W-2:0], rem_ge};
            if (cnt_ff == CNT_W'(RES_W - 1)) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               scan_in  = cmd_ff.end_of_scan ? 1'b1 : scan_all;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         scan_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         scan_ff  <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      sum_ff     <= sum_in;
      low_ff     <= low_in;
      ovf_ff     <= ovf_in;
      diff_ff    <= diff_in;
      prod_lo_ff <= prod_lo_in;
      prod_hi_ff <= prod_hi_in;
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      cnt_ff     <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (smp_we) begin
         smp_mem[smp_waddr] <= smp_wdata;
      end
      smp_rd_ff <= smp_mem[smp_addr];
   end

   always_ff @(posedge clock) begin
      if (chan_we) begin
         chan_mem[chan_waddr] <= chan_wdata;
      end
      chan_rd_ff <= chan_mem[ch_idx];
   end

endmodule

/* design/drma_checker.sv */
module drma_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        full,
   input logic                        empty,
   input logic                        pop,
   input logic [drma_pkg::RES_W-1:0]  rsp_resistance_ohms,
   input logic                        rsp_reading_valid,
   input logic                        rsp_scan_done,
   input logic                        rsp_scan_valid
);

   // memory sweep must block requests right after reset
   a_reset_blocks_requests: assert property (@(posedge clock) reset |=> full)
      else $error("full low in the cycle after reset");

   a_reset_drains_responses: assert property (@(posedge clock) reset |=> empty)
      else $error("response pending in the cycle after reset");

   a_invalid_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_reading_valid) |-> (rsp_resistance_ohms == '0))
      else $error("invalid reading with nonzero resistance");

   a_scan_valid_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_scan_valid) |-> rsp_scan_done)
      else $error("scan_valid without scan_done");

   a_stalled_response_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_resistance_ohms)))
      else $error("stalled response changed");

endmodule

bind divider_resistance_moving_average_top drma_checker u_checker (.*);

/* tb/testbench.sv */
module testbench;
   import drma_pkg::*;

   localparam int          CYCLE_LIMIT    = 400000;
   localparam int          PHASE_ITEMS    = 150;
   localparam int          PHASE_COUNT    = 9;
   localparam int          SETTLE_CYCLES  = 64;
   localparam int          HOLD_CYCLES    = 400;
   localparam int          SLOT_W         = $clog2(DEF_WINDOW);
   localparam logic [23:0] OHMS_MAX       = 24'hFFFFFF;
   localparam int          DIRECTED_ROWS  = 16;

   typedef struct packed {
      req_kind_type       kind;
      logic [CH_IN_W-1:0] ch;
      logic [SMP_W-1:0]   smp;
      logic               eos;
      logic               typed;
      logic [RES_W-1:0]   res;
      logic               ok;
      logic               sv;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   push = 1'b0;
   logic                   full;
   logic                   req_type = 1'b0;
   logic [CH_IN_W-1:0]     req_channel = '0;
   logic [SMP_W-1:0]       req_sample = '0;
   logic                   req_end_of_scan = 1'b0;
   logic                   empty;
   logic                   pop = 1'b0;
   logic [CH_IN_W-1:0]     rsp_channel_out;
   logic [RES_W-1:0]       rsp_resistance_ohms;
   logic                   rsp_reading_valid;
   logic                   rsp_scan_done;
   logic                   rsp_scan_valid;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   divider_resistance_moving_average_top uut (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_type            (req_type),
      .req_channel         (req_channel),
      .req_sample          (req_sample),
      .req_end_of_scan     (req_end_of_scan),
      .empty               (empty),
      .pop                 (pop),
      .rsp_channel_out     (rsp_channel_out),
      .rsp_resistance_ohms (rsp_resistance_ohms),
      .rsp_reading_valid   (rsp_reading_valid),
      .rsp_scan_done       (rsp_scan_done),
      .rsp_scan_valid      (rsp_scan_valid),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow of the block state
   logic [SMP_W-1:0]  window_ring [DEF_CHANNELS][DEF_WINDOW];
   logic [15:0]       ring_total  [DEF_CHANNELS];
   logic [SLOT_W-1:0] ring_slot   [DEF_CHANNELS];
   bit                scan_clean;
   logic [FIX_W-1:0]  fixed_ohms;
   logic [LIM_W-1:0]  open_limit;

   rsp_item_type expected_readings [$];
   stim_row_type pending_hints [$];
   stim_row_type directed_rows [DIRECTED_ROWS];

   int error_count     = 0;
   int items_sent      = 0;
   int measures_seen   = 0;
   int readings_popped = 0;
   int valid_readings  = 0;
   int scans_closed    = 0;
   int stall_cycles    = 0;

   bit       idle_on      = 1'b1;
   bit       hold_trigger = 1'b0;
   bit       hold_done    = 1'b0;
   int       hold_left    = 0;

   initial begin
      scan_clean = 1'b1;
      fixed_ohms = FIX_RESET;
      open_limit = LIM_RESET;
      for (int c = 0; c < DEF_CHANNELS; c++) begin
         ring_total[c] = '0;
         ring_slot[c]  = '0;
         for (int s = 0; s < DEF_WINDOW; s++) window_ring[c][s] = '0;
      end
   end

   // moving window update plus divider resistance estimate
   task automatic estimate_reading(input cmd_item_type cmd, output bit produced,
                                   output rsp_item_type r);
      int unsigned       slot;
      int unsigned       ch;
      longint unsigned   total;
      longint unsigned   span;
      longint unsigned   num;
      longint unsigned   quot;
      bit                ok;
      ch   = cmd.channel;
      slot = ring_slot[ch];
      ring_total[ch] = 16'(int'(ring_total[ch]) - int'(window_ring[ch][slot]) + int'(cmd.sample));
      window_ring[ch][slot] = cmd.sample;
      ring_slot[ch] = SLOT_W'((slot + 1) % DEF_WINDOW);
      produced = (cmd.req_kind == REQ_MEASURE);
      r = '0;
      if (produced) begin
         total = ring_total[ch];
         span  = longint'(ADC_FULL) * DEF_WINDOW - total;
         ok    = 1'b1;
         quot  = 0;
         // below 1 mV at the node counts as no contact
         if (longint'(LOW_MV_SCALE) * total < longint'(ADC_FULL) * DEF_WINDOW || total == 0) begin
            ok = 1'b0;
         end else begin
            num = longint'(fixed_ohms) * span;
            if (num > longint'(open_limit) * total) begin
               ok = 1'b0;
            end else begin
               quot = num / total;
               if (quot > OHMS_MAX) quot = OHMS_MAX;
            end
         end
         scan_clean = scan_clean && ok;
         r.channel_out     = cmd.channel;
         r.resistance_ohms = quot[RES_W-1:0];
         r.reading_valid   = ok;
         r.scan_done       = cmd.end_of_scan;
         r.scan_valid      = cmd.end_of_scan && scan_clean;
         if (cmd.end_of_scan) scan_clean = 1'b1;
      end
   endtask

   task automatic check_field(input string name, input longint exp_v, input longint act_v);
      if (exp_v != act_v) begin
         $display("%0t mismatch on %s: expected %0d actual %0d", $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : observe
      cmd_item_type cmd;
      rsp_item_type r;
      stim_row_type hint;
      bit           produced;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index_type'(csr_index) == CSR_FIXED_OHMS) fixed_ohms = csr_data[FIX_W-1:0];
            else open_limit = csr_data[LIM_W-1:0];
         end
         if (push && full) stall_cycles++;
         if (push && !full) begin
            hint = pending_hints.pop_front();
            cmd.req_kind    = req_kind_type'(req_type);
            cmd.channel     = req_channel;
            cmd.sample      = req_sample;
            cmd.end_of_scan = req_end_of_scan;
            estimate_reading(cmd, produced, r);
            if (produced) begin
               measures_seen++;
               if (hint.typed) begin
                  r.resistance_ohms = hint.res;
                  r.reading_valid   = hint.ok;
                  r.scan_valid      = hint.sv;
               end
               expected_readings.push_back(r);
            end
         end
         if (pop && !empty) begin
            if (expected_readings.size() == 0) begin
               $display("%0t response with nothing expected: channel %0d ohms %0d",
                        $time, rsp_channel_out, rsp_resistance_ohms);
               error_count++;
            end else begin
               r = expected_readings.pop_front();
               readings_popped++;
               if (rsp_reading_valid) valid_readings++;
               if (rsp_scan_done) scans_closed++;
               check_field("channel_out", r.channel_out, rsp_channel_out);
               check_field("resistance_ohms", r.resistance_ohms, rsp_resistance_ohms);
               check_field("reading_valid", r.reading_valid, rsp_reading_valid);
               check_field("scan_done", r.scan_done, rsp_scan_done);
               check_field("scan_valid", r.scan_valid, rsp_scan_valid);
            end
         end
      end
   end

   // response side: random idling and one long hold-off
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         pop <= 1'b0;
         if (hold_left == 1) hold_done <= 1'b1;
      end else if (hold_trigger && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         pop <= 1'b0;
      end else begin
         pop <= idle_on ? ($urandom_range(99) >= 6) : 1'b1;
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles", cycles);
      $display("testbench failed");
      $finish;
   end

   function automatic stim_row_type make_cmd(req_kind_type kind, int ch, int smp, bit eos);
      stim_row_type row;
      row      = '0;
      row.kind = kind;
      row.ch   = CH_IN_W'(ch);
      row.smp  = SMP_W'(smp);
      row.eos  = eos;
      return row;
   endfunction

   function automatic int pick_sample();
      case ($urandom_range(3))
         0: return $urandom_range(40);
         1: return $urandom_range(4095, 4000);
         default: return $urandom_range(4095);
      endcase
   endfunction

   task automatic send_cmd(input stim_row_type row);
      while (idle_on && $urandom_range(99) < 6) begin
         push <= 1'b0;
         @(posedge clock);
      end
      pending_hints.push_back(row);
      push            <= 1'b1;
      req_type        <= row.kind;
      req_channel     <= row.ch;
      req_sample      <= row.smp;
      req_end_of_scan <= row.eos;
      do @(posedge clock); while (full);
      items_sent++;
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      @(posedge clock);
      while (expected_readings.size() != 0) @(posedge clock);
   endtask

   task automatic write_settings(input logic [CSR_DATA_W-1:0] fix_word,
                                 input logic [CSR_DATA_W-1:0] lim_word);
      csr_index_type idx;
      for (int i = 0; i < 2; i++) begin
         idx = (i == 0) ? CSR_FIXED_OHMS : CSR_OPEN_LIMIT;
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= (i == 0) ? fix_word : lim_word;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   // one scan: a few channels, optional primes before each measure
   task automatic run_scan();
      int n;
      int ch;
      n = $urandom_range(1, DEF_CHANNELS);
      for (int i = 0; i < n; i++) begin
         ch = $urandom_range(DEF_CHANNELS - 1);
         repeat ($urandom_range(2))
            send_cmd(make_cmd(REQ_PRIME, ch, pick_sample(), $urandom_range(1)));
         send_cmd(make_cmd(REQ_MEASURE, ch, pick_sample(), i == n - 1));
      end
   endtask

   // flood one channel window with a single value, then measure
   task automatic run_fill();
      int ch;
      int level;
      ch = $urandom_range(DEF_CHANNELS - 1);
      case ($urandom_range(4))
         0: level = 0;
         1: level = 4095;
         2: level = 1;
         3: level = 2;
         default: level = $urandom_range(4095);
      endcase
      repeat (DEF_WINDOW) send_cmd(make_cmd(REQ_PRIME, ch, level, $urandom_range(1)));
      send_cmd(make_cmd(REQ_MEASURE, ch, level, $urandom_range(1)));
   endtask

   initial begin : stimulus
      int                      start;
      int                      pick;
      bit                      held;
      bit                      paused;
      logic [CSR_DATA_W-1:0]   fix_word;
      logic [CSR_DATA_W-1:0]   lim_word;
      held   = 1'b0;
      paused = 1'b0;

      directed_rows[0]  = make_cmd(REQ_MEASURE, 0, 0, 0);
      directed_rows[0].typed = 1'b1;                  // empty window reads as no contact
      directed_rows[1]  = make_cmd(REQ_MEASURE, 0, 4095, 1);
      directed_rows[2]  = make_cmd(REQ_PRIME, 1, 19, 1);   // flag on prime must not close scan
      directed_rows[3]  = make_cmd(REQ_MEASURE, 1, 0, 1);
      directed_rows[3].typed = 1'b1;                  // sum 19 sits just under 1 mV
      directed_rows[4]  = make_cmd(REQ_PRIME, 2, 20, 0);
      directed_rows[5]  = make_cmd(REQ_MEASURE, 2, 0, 0);  // over the open limit
      directed_rows[6]  = make_cmd(REQ_PRIME, 7, 4095, 1);
      directed_rows[7]  = make_cmd(REQ_MEASURE, 3, 2048, 0);
      directed_rows[8]  = make_cmd(REQ_MEASURE, 4, 4095, 1);
      directed_rows[9]  = make_cmd(REQ_MEASURE, 5, 4095, 1);
      directed_rows[10] = make_cmd(REQ_MEASURE, 6, 1, 0);
      directed_rows[11] = make_cmd(REQ_MEASURE, 7, 0, 1);
      directed_rows[12] = make_cmd(REQ_MEASURE, 6, 4094, 0);
      directed_rows[13] = make_cmd(REQ_MEASURE, 5, 2730, 1);
      directed_rows[14] = make_cmd(REQ_PRIME, 3, 4095, 0);
      directed_rows[15] = make_cmd(REQ_MEASURE, 3, 4095, 1);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++) send_cmd(directed_rows[i]);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_drained();
         repeat (SETTLE_CYCLES) @(posedge clock);
         case (phase)
            0: begin
               fix_word = {4'($urandom_range(15)), 20'hFFFFF};
               lim_word = 24'hFFFFFF;
            end
            1: begin
               fix_word = 24'd1;
               lim_word = 24'd1;
            end
            2: begin
               fix_word = {4'hF, 20'd0};
               lim_word = 24'd0;
            end
            3: begin
               fix_word = 24'd1000000;
               lim_word = 24'd16777215;
            end
            4: begin
               fix_word = 24'd4700;
               lim_word = 24'd100000;
            end
            default: begin
               fix_word = {4'($urandom_range(15)), 20'($urandom_range(1, 1000000))};
               lim_word = 24'($urandom_range(1, 24'hFFFFFF));
            end
         endcase
         write_settings(fix_word, lim_word);
         idle_on <= (phase != 4);
         start = items_sent;
         while (items_sent - start < PHASE_ITEMS) begin
            if (phase == 3 && !held && items_sent - start >= 40) begin
               hold_trigger <= 1'b1;
               held = 1'b1;
            end
            if (phase == 5 && !paused && items_sent - start >= 75) begin
               wait_drained();
               paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 60) run_scan();
            else if (pick < 72) run_fill();
            else send_cmd(make_cmd(req_kind_type'($urandom_range(1)),
                                   $urandom_range(DEF_CHANNELS - 1),
                                   $urandom_range(4095), $urandom_range(1)));
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("sent %0d transactions, %0d measures, %0d responses checked over %0d settings",
               items_sent, measures_seen, readings_popped, PHASE_COUNT + 1);
      $display("%0d valid readings, %0d scans closed, %0d cycles with input held off",
               valid_readings, scans_closed, stall_cycles);
      if (error_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("%0d mismatches", error_count);
         $display("testbench failed");
      end
      $finish;
   end

endmodule
